// ===== hdl/fmagd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmagd_pkg: shared types and constants of the FM audio gain stage
// Fixed widths, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package fmagd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int GAIN_W = 20;
    localparam int PEAK_W = 17;
    localparam int COUNT_W = 20;
    localparam int ALPHA_W = 16;
    localparam int PREV_W = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH  = 2'd0,
        CFG_DEEMPH_ENABLE  = 2'd1,
        CFG_DEEMPH_ALPHA   = 2'd2,
        CFG_GAIN_NUMERATOR = 2'd3
    } t_cfg_idx;

    localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RST = 20'd96000;
    localparam logic               DEEMPH_ENABLE_RST = 1'b1;
    localparam logic [ALPHA_W-1:0] DEEMPH_ALPHA_RST  = 16'd6183;
    localparam logic [GAIN_W-1:0]  GAIN_NUM_RST      = 20'd140183;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = 20'hFFFFF;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR = 20'd3277;
    localparam logic [16:0]       SMOOTH_OLD = 17'd62259;
    localparam logic [16:0]       SMOOTH_NEW = 17'd3277;
    localparam logic [11:0]       MAG_SCALE  = 12'd2500;

endpackage

// ===== hdl/fmagd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmagd_if: channel interfaces of the FM audio gain stage
// Input sample channel, output audio channel and register write channel.
// ----------------------------------------------------------------------------
interface fmagd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fmagd_pkg::SAMPLE_W-1:0]   demod_sample;
    logic signed [fmagd_pkg::SAMPLE_W-1:0]   in_i;
    logic signed [fmagd_pkg::SAMPLE_W-1:0]   in_q;

    modport source (output valid, output demod_sample, output in_i, output in_q,
                    input ready);
    modport sink (input valid, input demod_sample, input in_i, input in_q,
                  output ready);
endinterface

interface fmagd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fmagd_pkg::SAMPLE_W-1:0]   audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink (input valid, input audio_sample, output ready);
endinterface

interface fmagd_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [fmagd_pkg::CFG_IDX_W-1:0]         index;
    logic [fmagd_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fmagd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmagd_mul: shared signed multiplier with registered product
// The product register loads only when enabled and holds otherwise.
// ----------------------------------------------------------------------------
module fmagd_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [fmagd_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [fmagd_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [fmagd_pkg::MUL_P_W-1:0]  o_prod
);

    logic signed [fmagd_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= fmagd_pkg::MUL_P_W'(i_a) * fmagd_pkg::MUL_P_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/fm_audio_gain_deemphasis.sv =====
`timescale 1ns / 1ps
// A word passes the squares, the 22-step magnitude root and the peak update; a window end
// adds the 30-step gain division (skipped on a zero peak), clamp and smoothing. The filter
// (skipped with deemphasis off) and output scaling follow; a full output register not yet
// taken holds the last step. No new word is taken before the last one reaches the output
// register, which lets the next word in while the previous one waits.
// Reset (i_rst_n low, synchronous) restores register defaults and zeroes all AGC state.
// ----------------------------------------------------------------------------
// fm_audio_gain_deemphasis: FM audio deemphasis with peak-tracking AGC
// A small sequencer drives one shared multiplier and one shared subtract/compare
// unit through the magnitude root, gain division, smoothing, filter and output scaling.
// ----------------------------------------------------------------------------
module fm_audio_gain_deemphasis (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fmagd_in_if.sink     i_in,
    fmagd_out_if.source  o_out,
    fmagd_cfg_if.sink    i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQI, S_SQQ, S_PW, S_P2500, S_SQLD, S_SQRT, S_PEAK,
        S_DIV, S_DIVDN, S_CLAMP, S_SM1, S_SM2, S_SM3,
        S_DEEMPH, S_DEEMPH2, S_OUT, S_OUT2
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [fmagd_pkg::COUNT_W-1:0] r_wlen;
    logic                          r_den;
    logic [fmagd_pkg::ALPHA_W-1:0] r_alpha;
    logic [fmagd_pkg::GAIN_W-1:0]  r_gnum;

    // Persistent state across words.
    logic [fmagd_pkg::PEAK_W-1:0]         r_peak;
    logic [fmagd_pkg::COUNT_W-1:0]        r_wcount;
    logic [fmagd_pkg::GAIN_W-1:0]         r_cur_gain;
    logic [fmagd_pkg::GAIN_W-1:0]         r_avg_gain;
    logic signed [fmagd_pkg::PREV_W-1:0]  r_prev;

    // Per-word working registers.
    logic signed [fmagd_pkg::SAMPLE_W-1:0] r_x;
    logic signed [fmagd_pkg::SAMPLE_W-1:0] r_i;
    logic signed [fmagd_pkg::SAMPLE_W-1:0] r_q;
    logic [37:0]                           r_acc;
    logic [42:0]                           r_sx;
    logic [42:0]                           r_sr;
    logic [42:0]                           r_sb;
    logic [16:0]                           r_drem;
    logic [29:0]                           r_dq;
    logic [4:0]                            r_dcnt;
    logic [fmagd_pkg::GAIN_W-1:0]          r_g;
    logic signed [fmagd_pkg::PREV_W-1:0]   r_y;

    // Output register.
    logic                                  r_out_valid;
    logic signed [fmagd_pkg::SAMPLE_W-1:0] r_out_data;

    // Shared multiplier.
    logic                                  mul_en;
    logic signed [fmagd_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [fmagd_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [fmagd_pkg::MUL_P_W-1:0]  prod;

    fmagd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Shared subtract/compare unit: the root and the divider take turns on it.
    logic [43:0] cmp_a;
    logic [43:0] cmp_b;
    logic [44:0] cmp_diff;
    logic        cmp_ge;
    logic [17:0] rem_shift;

    assign rem_shift = {r_drem, r_dq[29]};

    always_comb begin
        if (r_state == S_DIV) begin
            cmp_a = 44'(rem_shift);
            cmp_b = 44'(r_peak);
        end else begin
            cmp_a = {1'b0, r_sx};
            cmp_b = {1'b0, r_sr} + {1'b0, r_sb};
        end
        cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        cmp_ge   = ~cmp_diff[44];
    end

    // Filter difference: the sample in Q1.23 minus the previous filter output.
    logic signed [24:0] dm_diff;
    assign dm_diff = {r_x[15], r_x, 8'b0} - {r_prev[23], r_prev};

    // The multiplier sees only the operands of the step that needs it.
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_SQI: begin
                mul_en = 1'b1;
                mul_a  = {{17{r_i[15]}}, r_i};
                mul_b  = {{6{r_i[15]}}, r_i};
            end
            S_SQQ: begin
                mul_en = 1'b1;
                mul_a  = {{17{r_q[15]}}, r_q};
                mul_b  = {{6{r_q[15]}}, r_q};
            end
            S_P2500: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_acc[31:0]};
                mul_b  = 22'(fmagd_pkg::MAG_SCALE);
            end
            S_CLAMP: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_avg_gain);
                mul_b  = 22'(fmagd_pkg::SMOOTH_OLD);
            end
            S_SM1: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_g);
                mul_b  = 22'(fmagd_pkg::SMOOTH_NEW);
            end
            S_DEEMPH: begin
                mul_en = 1'b1;
                mul_a  = {{8{dm_diff[24]}}, dm_diff};
                mul_b  = 22'(r_alpha);
            end
            S_OUT: begin
                mul_en = 1'b1;
                mul_a  = {{9{r_y[23]}}, r_y};
                mul_b  = 22'(r_cur_gain);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Peak and window bookkeeping, evaluated when the root is done.
    logic [fmagd_pkg::PEAK_W-1:0] mag;
    logic [fmagd_pkg::PEAK_W-1:0] peak_upd;
    logic [20:0]                  wcnt_inc;
    logic                         win_end;

    assign mag      = r_sr[21:5];
    assign peak_upd = (mag > r_peak) ? mag : r_peak;
    assign wcnt_inc = {1'b0, r_wcount} + 21'd1;
    assign win_end  = wcnt_inc >= {1'b0, r_wlen};

    // Rounded filter update and rounded output scaling, both half up.
    logic signed [fmagd_pkg::MUL_P_W-1:0] dm_bias;
    logic signed [39:0]                   dm_sum;
    logic signed [fmagd_pkg::PREV_W-1:0]  dm_sat;
    logic signed [fmagd_pkg::MUL_P_W-1:0] out_bias;
    logic signed [30:0]                   out_full;
    logic signed [fmagd_pkg::SAMPLE_W-1:0] out_sat;
    logic [20:0]                          sm_gain;
    logic [fmagd_pkg::GAIN_W-1:0]         sm_sat;

    always_comb begin
        dm_bias  = prod + 55'sd32768;
        dm_sum   = 40'($signed(dm_bias[54:16])) + 40'(r_prev);
        if (dm_sum > 40'sd8388607) begin
            dm_sat = 24'sh7FFFFF;
        end else if (dm_sum < -40'sd8388608) begin
            dm_sat = -24'sh800000;
        end else begin
            dm_sat = dm_sum[23:0];
        end

        out_bias = prod + 55'sd8388608;
        out_full = out_bias[54:24];
        if (out_full > 31'sd32767) begin
            out_sat = 16'sh7FFF;
        end else if (out_full < -31'sd32768) begin
            out_sat = -16'sh8000;
        end else begin
            out_sat = out_full[15:0];
        end

        sm_gain = r_acc[36:16];
        sm_sat  = sm_gain[20] ? fmagd_pkg::GAIN_MAX : sm_gain[19:0];
    end

    logic out_free;
    assign out_free = ~r_out_valid | o_out.ready;

    // The output register empties when taken and fills when the last step finishes.
    logic n_out_valid;
    always_comb begin
        n_out_valid = r_out_valid & ~o_out.ready;
        if (r_state == S_OUT2 && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.audio_sample = r_out_data;
    assign i_cfg.ready        = 1'b1;

    // Register writes are taken in any state; the host must make its writes only while idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= fmagd_pkg::WINDOW_LENGTH_RST;
            r_den   <= fmagd_pkg::DEEMPH_ENABLE_RST;
            r_alpha <= fmagd_pkg::DEEMPH_ALPHA_RST;
            r_gnum  <= fmagd_pkg::GAIN_NUM_RST;
        end else if (i_cfg.valid) begin
            unique case (fmagd_pkg::t_cfg_idx'(i_cfg.index))
                fmagd_pkg::CFG_WINDOW_LENGTH:  r_wlen  <= i_cfg.data;
                fmagd_pkg::CFG_DEEMPH_ENABLE:  r_den   <= i_cfg.data[0];
                fmagd_pkg::CFG_DEEMPH_ALPHA:   r_alpha <= i_cfg.data[15:0];
                fmagd_pkg::CFG_GAIN_NUMERATOR: r_gnum  <= i_cfg.data;
            endcase
        end
    end

    // Sequencer with its working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_wcount    <= '0;
            r_cur_gain  <= '0;
            r_avg_gain  <= '0;
            r_prev      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x     <= i_in.demod_sample;
                        r_i     <= i_in.in_i;
                        r_q     <= i_in.in_q;
                        r_state <= S_SQI;
                    end
                end
                S_SQI: begin
                    r_state <= S_SQQ;
                end
                S_SQQ: begin
                    r_acc   <= prod[37:0];
                    r_state <= S_PW;
                end
                S_PW: begin
                    r_acc   <= r_acc + prod[37:0];
                    r_state <= S_P2500;
                end
                S_P2500: begin
                    r_state <= S_SQLD;
                end
                S_SQLD: begin
                    // Start the root at the top even power; leading steps are no-ops.
                    r_sx    <= prod[42:0];
                    r_sr    <= '0;
                    r_sb    <= 43'(1) << 42;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (cmp_ge) begin
                        r_sx <= cmp_diff[42:0];
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb <= r_sb >> 2;
                    if (r_sb[0]) begin
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    r_peak <= peak_upd;
                    if (!win_end) begin
                        r_wcount <= wcnt_inc[19:0];
                        r_state  <= S_DEEMPH;
                    end else if (peak_upd != '0) begin
                        r_dq    <= {r_gnum, 10'b0};
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        // Zero peak keeps the old gain.
                        r_g     <= r_cur_gain;
                        r_state <= S_CLAMP;
                    end
                end
                S_DIV: begin
                    r_drem <= cmp_ge ? cmp_diff[16:0] : rem_shift[16:0];
                    r_dq   <= {r_dq[28:0], cmp_ge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd29) begin
                        r_state <= S_DIVDN;
                    end
                end
                S_DIVDN: begin
                    r_g     <= (r_dq[29:20] != '0) ? fmagd_pkg::GAIN_MAX : r_dq[19:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_g <= fmagd_pkg::GAIN_FLOOR) begin
                        r_g <= fmagd_pkg::GAIN_FLOOR;
                    end
                    r_state <= S_SM1;
                end
                S_SM1: begin
                    r_acc   <= prod[37:0];
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    r_acc   <= r_acc + prod[37:0] + 38'd32768;
                    r_state <= S_SM3;
                end
                S_SM3: begin
                    r_cur_gain <= sm_sat;
                    r_avg_gain <= sm_sat;
                    r_wcount   <= '0;
                    r_peak     <= '0;
                    r_state    <= S_DEEMPH;
                end
                S_DEEMPH: begin
                    if (r_den) begin
                        r_state <= S_DEEMPH2;
                    end else begin
                        r_y     <= {r_x, 8'b0};
                        r_state <= S_OUT;
                    end
                end
                S_DEEMPH2: begin
                    r_y     <= dm_sat;
                    r_prev  <= dm_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_OUT2;
                end
                S_OUT2: begin
                    // Product holds while the previous word is still unclaimed.
                    if (out_free) begin
                        r_out_data  <= out_sat;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("block still ready after taking a word");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_peak != '0))
        else $error("gain division started with a zero peak");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEAK) |-> (r_sr[42:22] == '0))
        else $error("magnitude root out of range");

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SM3) |=> (r_peak == '0 && r_wcount == '0
                                && r_cur_gain == r_avg_gain))
        else $error("window end did not clear peak and count");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fm_audio_gain_deemphasis
// Drives sample words with random gaps and random output back-pressure. It
// predicts each audio word with a bit-exact model of the peak AGC and the
// deemphasis filter, and compares every word the block returns in order.
// ----------------------------------------------------------------------------
module testbench;

    // The limit leaves a wide margin over a window end with a division, even
    // with the longest sender gap and receiver stall added to it.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1950;
    // The last stretch of the random part runs without gaps or stalls.
    localparam int QUIET_TAIL     = 300;
    // Cycles to wait after the last word, beyond the longest block latency.
    localparam int DRAIN_CYCLES   = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fmagd_in_if  sample_ch ();
    fmagd_out_if audio_ch ();
    fmagd_cfg_if cfg_ch ();

    fm_audio_gain_deemphasis dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (audio_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // Register copies that the predictor keeps. They are updated when a
    // register write is accepted.
    logic [fmagd_pkg::COUNT_W-1:0] window_len;
    logic                          deemph_on;
    logic [fmagd_pkg::ALPHA_W-1:0] alpha;
    logic [fmagd_pkg::GAIN_W-1:0]  gain_num;

    // State of the AGC and the filter that the predictor keeps.
    logic [fmagd_pkg::PEAK_W-1:0]         peak_mag;
    logic [fmagd_pkg::COUNT_W-1:0]        sample_count;
    logic [fmagd_pkg::GAIN_W-1:0]         applied_gain;
    logic [fmagd_pkg::GAIN_W-1:0]         smoothed_gain;
    logic signed [fmagd_pkg::PREV_W-1:0]  filter_hist;

    // Audio words that are predicted and not yet returned, oldest first.
    logic signed [fmagd_pkg::SAMPLE_W-1:0] expected_audio[$];
    logic signed [fmagd_pkg::SAMPLE_W-1:0] want_audio;

    int errors;
    int idle_cycles;
    int stall_left;
    int random_sent;
    bit input_gaps;
    bit output_stalls;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Integer square root, one result bit at a time. The argument stays
    // below 2^43, so 24 result bits are enough.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Arithmetic right shift that rounds half up, toward plus infinity.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void reset_model();
        window_len    = fmagd_pkg::WINDOW_LENGTH_RST;
        deemph_on     = fmagd_pkg::DEEMPH_ENABLE_RST;
        alpha         = fmagd_pkg::DEEMPH_ALPHA_RST;
        gain_num      = fmagd_pkg::GAIN_NUM_RST;
        peak_mag      = '0;
        sample_count  = '0;
        applied_gain  = '0;
        smoothed_gain = '0;
        filter_hist   = '0;
    endfunction

    function automatic void apply_register(input logic [fmagd_pkg::CFG_IDX_W-1:0] index,
                                           input logic [fmagd_pkg::CFG_DATA_W-1:0] value);
        case (fmagd_pkg::t_cfg_idx'(index))
            fmagd_pkg::CFG_WINDOW_LENGTH:  window_len = value[fmagd_pkg::COUNT_W-1:0];
            fmagd_pkg::CFG_DEEMPH_ENABLE:  deemph_on = value[0];
            fmagd_pkg::CFG_DEEMPH_ALPHA:   alpha = value[fmagd_pkg::ALPHA_W-1:0];
            fmagd_pkg::CFG_GAIN_NUMERATOR: gain_num = value[fmagd_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the AGC and the filter by one sample and returns the audio
    // word that the block should produce for it.
    function automatic logic signed [fmagd_pkg::SAMPLE_W-1:0] step_audio(
        input logic signed [fmagd_pkg::SAMPLE_W-1:0] demod,
        input logic signed [fmagd_pkg::SAMPLE_W-1:0] in_i,
        input logic signed [fmagd_pkg::SAMPLE_W-1:0] in_q
    );
        longint          vi;
        longint          vq;
        longint          y;
        longint          diff;
        longint          hist;
        longint          scaled;
        longint unsigned power;
        longint unsigned mag;
        longint unsigned quot;
        longint unsigned gain;
        longint unsigned smooth;
        int unsigned     next_count;

        // The peak of 50*|I+jQ| is kept in Q7.10 counts.
        vi = longint'(in_i);
        vq = longint'(in_q);
        power = vi * vi + vq * vq;
        mag = int_sqrt(power * 2500) >> 5;
        if (mag > peak_mag) begin
            peak_mag = mag[fmagd_pkg::PEAK_W-1:0];
        end

        // A zero window length, or a length lowered below the running
        // count, ends the window at this sample.
        next_count = sample_count + 1;
        if (next_count >= window_len) begin
            gain = 64'(applied_gain);
            if (peak_mag != 0) begin
                quot = (longint'(gain_num) << 10) / peak_mag;
                gain = (quot > fmagd_pkg::GAIN_MAX) ? 64'(fmagd_pkg::GAIN_MAX) : quot;
            end
            if (gain <= fmagd_pkg::GAIN_FLOOR) begin
                gain = 64'(fmagd_pkg::GAIN_FLOOR);
            end
            smooth = (64'(fmagd_pkg::SMOOTH_OLD) * 64'(smoothed_gain)
                      + 64'(fmagd_pkg::SMOOTH_NEW) * gain + 64'd32768) >> 16;
            if (smooth > fmagd_pkg::GAIN_MAX) begin
                smooth = 64'(fmagd_pkg::GAIN_MAX);
            end
            applied_gain  = smooth[fmagd_pkg::GAIN_W-1:0];
            smoothed_gain = smooth[fmagd_pkg::GAIN_W-1:0];
            sample_count  = '0;
            peak_mag      = '0;
        end else begin
            sample_count = next_count[fmagd_pkg::COUNT_W-1:0];
        end

        // The one-pole filter runs in Q1.23. When it is off, its history is kept.
        y = longint'(demod);
        y = y * 256;
        if (deemph_on) begin
            hist = longint'(filter_hist);
            diff = y - hist;
            y = hist + round_shift(diff * longint'(alpha), 16);
            if (y > 64'sd8388607) begin
                y = 64'sd8388607;
            end
            if (y < -64'sd8388608) begin
                y = -64'sd8388608;
            end
            filter_hist = y[fmagd_pkg::PREV_W-1:0];
        end

        scaled = round_shift(y * longint'(applied_gain), 24);
        if (scaled > 64'sd32767) begin
            scaled = 64'sd32767;
        end
        if (scaled < -64'sd32768) begin
            scaled = -64'sd32768;
        end
        return scaled[fmagd_pkg::SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Monitors. All channels are sampled at the rising edge.
    // ------------------------------------------------------------------

    // Register writes and accepted samples update the predictor in the order
    // the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(cfg_ch.index, cfg_ch.data);
            end
            if (sample_ch.valid && sample_ch.ready) begin
                expected_audio.push_back(step_audio(sample_ch.demod_sample,
                                                    sample_ch.in_i, sample_ch.in_q));
            end
        end
    end

    // Each returned audio word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && audio_ch.valid && audio_ch.ready) begin
            if (expected_audio.size() == 0) begin
                $display("%0t ns: audio word with nothing expected: expected none, got %0d",
                         $time, audio_ch.audio_sample);
                errors++;
            end else begin
                want_audio = expected_audio.pop_front();
                if (audio_ch.audio_sample !== want_audio) begin
                    $display("%0t ns: audio_sample mismatch: expected %0d, got %0d",
                             $time, want_audio, audio_ch.audio_sample);
                    errors++;
                end
            end
        end
    end

    // The watchdog ends the run if no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (audio_ch.valid && audio_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog expired", $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Output back-pressure comes in random bursts of stalled cycles.
    // The signal is driven at the falling edge.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            audio_ch.ready <= 1'b0;
        end else if (output_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            audio_ch.ready <= 1'b0;
        end else begin
            audio_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Inputs change at the falling edge.
    // ------------------------------------------------------------------

    // Sends one sample word and returns just after the edge that accepts it.
    // Valid stays high, so back-to-back words see no drop in valid. A random
    // gap, if one is drawn, comes before the word.
    task automatic send_sample(input logic signed [fmagd_pkg::SAMPLE_W-1:0] demod,
                               input logic signed [fmagd_pkg::SAMPLE_W-1:0] in_i,
                               input logic signed [fmagd_pkg::SAMPLE_W-1:0] in_q);
        int gap;
        if (input_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sample_ch.valid        <= 1'b1;
        sample_ch.demod_sample <= demod;
        sample_ch.in_i         <= in_i;
        sample_ch.in_q         <= in_q;
        do begin
            @(posedge i_clk);
        end while (!(sample_ch.valid && sample_ch.ready));
    endtask

    task automatic end_samples();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
    endtask

    task automatic write_register(input fmagd_pkg::t_cfg_idx index,
                                  input logic [fmagd_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Every sample yields exactly one audio word. An empty prediction queue
    // therefore means that the block is idle and registers may be written.
    task automatic wait_drained();
        while (expected_audio.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_all(input logic [fmagd_pkg::CFG_DATA_W-1:0] win,
                             input logic [fmagd_pkg::CFG_DATA_W-1:0] enable,
                             input logic [fmagd_pkg::CFG_DATA_W-1:0] coef,
                             input logic [fmagd_pkg::CFG_DATA_W-1:0] num);
        wait_drained();
        write_register(fmagd_pkg::CFG_WINDOW_LENGTH, win);
        write_register(fmagd_pkg::CFG_DEEMPH_ENABLE, enable);
        write_register(fmagd_pkg::CFG_DEEMPH_ALPHA, coef);
        write_register(fmagd_pkg::CFG_GAIN_NUMERATOR, num);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings. The window is far longer than this run, so the gain is
    // still zero and every word must be zero. The filter history still moves.
    task automatic test_power_on_defaults();
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'shFFFF, 16'sh0001);
        send_sample(16'shFFFF, 16'sh0000, 16'sh8000);
        end_samples();
    endtask

    // Zero window length with zero I/Q: each sample ends a window on a zero
    // peak. The old gain is kept, clamped to the floor and then smoothed.
    // The filter is off here.
    task automatic test_zero_peak_window();
        write_all(0, 0, 20'(fmagd_pkg::DEEMPH_ALPHA_RST), fmagd_pkg::GAIN_NUM_RST);
        send_sample(16'sh7FFF, 16'sh0000, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'sh0000);
        send_sample(16'sh4000, 16'sh0000, 16'sh0000);
        end_samples();
    endtask

    // Largest numerator over the smallest nonzero peak saturates the gain.
    // The largest filter coefficient lets the sample through almost unchanged.
    task automatic test_saturated_gain();
        write_all(1, 1, 20'hFFFF, 20'hFFFFF);
        send_sample(16'sh7FFF, 16'sh0001, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'shFFFF);
        send_sample(16'sh7FFF, 16'sh0001, 16'sh0001);
        send_sample(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh0001, 16'sh0002, 16'shFFFE);
        send_sample(16'shFFFF, 16'sh0000, 16'sh0001);
        end_samples();
    endtask

    // The window length is lowered mid-window. The next sample ends the
    // window because the count already passes the new length. A zero
    // coefficient freezes the filter output, and a zero numerator gives the
    // gain floor.
    task automatic test_window_shrink();
        write_all(10, 1, 0, 0);
        send_sample(16'sh1234, 16'sh4000, 16'shC000);
        send_sample(16'sh8000, 16'sh0100, 16'sh0100);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh0F0F, 16'sh0000, 16'sh0010);
        end_samples();
        wait_drained();
        write_register(fmagd_pkg::CFG_WINDOW_LENGTH, 2);
        send_sample(16'sh7FFF, 16'sh0020, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'sh0000);
        end_samples();
    endtask

    // Random phases. Each phase draws new register values and an I/Q scale,
    // then sends a run of random samples. The window lengths are mostly short,
    // so the gain moves a lot within a phase.
    task automatic test_random_phases();
        logic [fmagd_pkg::CFG_DATA_W-1:0]      win;
        logic [fmagd_pkg::CFG_DATA_W-1:0]      coef;
        logic [fmagd_pkg::CFG_DATA_W-1:0]      num;
        logic signed [fmagd_pkg::SAMPLE_W-1:0] demod;
        logic signed [fmagd_pkg::SAMPLE_W-1:0] vi;
        logic signed [fmagd_pkg::SAMPLE_W-1:0] vq;
        int                                    count;
        int                                    iq_shift;

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: win = 0;
                1: win = 1;
                2: win = 20'hFFFFF;
                3: win = 20'($urandom_range(50, 400));
                default: win = 20'($urandom_range(2, 30));
            endcase
            case ($urandom_range(0, 5))
                0: coef = 0;
                1: coef = 20'hFFFF;
                2: coef = 20'(fmagd_pkg::DEEMPH_ALPHA_RST);
                default: coef = 20'($urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 5))
                0: num = 0;
                1: num = 20'hFFFFF;
                2: num = fmagd_pkg::GAIN_NUM_RST;
                3: num = 20'($urandom_range(0, 4095));
                default: num = 20'($urandom_range(0, 20'hFFFFF));
            endcase
            iq_shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);

            write_all(win, 20'($urandom_range(0, 1)), coef, num);

            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                input_gaps    = 1'b0;
                output_stalls = 1'b0;
            end else begin
                input_gaps    = ($urandom_range(0, 3) != 0);
                output_stalls = ($urandom_range(0, 3) != 0);
            end

            count = $urandom_range(20, 100);
            if (count > RANDOM_ITEMS - random_sent) begin
                count = RANDOM_ITEMS - random_sent;
            end
            repeat (count) begin
                case ($urandom_range(0, 9))
                    0: demod = 16'sh7FFF;
                    1: demod = 16'sh8000;
                    default: demod = 16'($urandom);
                endcase
                case ($urandom_range(0, 19))
                    0, 1: begin
                        vi = '0;
                        vq = '0;
                    end
                    2: begin
                        vi = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        vq = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    default: begin
                        vi = 16'($urandom);
                        vq = 16'($urandom);
                        vi = vi >>> iq_shift;
                        vq = vq >>> iq_shift;
                    end
                endcase
                send_sample(demod, vi, vq);
                random_sent++;
            end
            end_samples();
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.demod_sample = '0;
        sample_ch.in_i         = '0;
        sample_ch.in_q         = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = fmagd_pkg::CFG_WINDOW_LENGTH;
        cfg_ch.data            = '0;
        audio_ch.ready         = 1'b0;
        errors                 = 0;
        idle_cycles            = 0;
        stall_left             = 0;
        random_sent            = 0;
        input_gaps             = 1'b1;
        output_stalls          = 1'b1;
        reset_model();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_zero_peak_window();
        test_saturated_gain();
        test_window_shrink();
        test_random_phases();

        // The watchdog bounds this wait if words go missing.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
